FILE: rtl/chs_pkg.sv
// Shared types and constants for the chained hash set.
package chs_pkg;

  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned BucketsDef   = 256;
  localparam int unsigned PoolNodesDef = 256;
  localparam int unsigned CfgBits      = 4;
  localparam int unsigned TotalBits    = 10;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef struct packed {
    logic found;
    logic status;
    logic [TotalBits-1:0] total;
  } result_t;

endpackage

FILE: rtl/chs_out_reg.sv
// Output register that holds one result beat until the receiver takes it.
module chs_out_reg
  import chs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    full_o,
  input  logic    m_axis_tready,
  output logic    m_axis_tvalid,
  output logic [15:0] m_axis_tdata
);
  logic    full_q, full_d;
  result_t res_q;

  assign full_d = load_i | (full_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign full_o        = full_q;
  assign m_axis_tvalid = full_q;
  assign m_axis_tdata  = {4'd0, res_q.total, res_q.status, res_q.found};
endmodule

FILE: rtl/chs_engine.sv
// Table engine: bucket, node and free-stack memories with the walk sequencer.
module chs_engine
  import chs_pkg::*;
#(
  parameter int unsigned KEY_BITS   = KeyBitsDef,
  parameter int unsigned BUCKETS    = BucketsDef,
  parameter int unsigned POOL_NODES = PoolNodesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CfgBits-1:0]  bits_i,
  input  logic                start_i,
  input  logic [1:0]          func_i,
  input  logic [31:0]         key_i,
  input  logic [31:0]         hash_i,
  output logic                busy_o,
  output logic                done_o,
  output result_t             res_o
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned FW = $clog2(POOL_NODES + 1);
  localparam int unsigned SW = $clog2(POOL_NODES + 1);
  localparam int unsigned CW = $clog2(POOL_NODES + BUCKETS + 1);
  localparam int unsigned IW = (BW > NW) ? BW : NW;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic                has_next;
    logic [NW-1:0]       next;
  } head_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                has_next;
    logic [NW-1:0]       next;
  } node_t;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HRD   = 9'b000000100,
    S_HEAD  = 9'b000001000,
    S_NODE  = 9'b000010000,
    S_FREE  = 9'b000100000,
    S_INS   = 9'b001000000,
    S_RMH   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  head_t head_mem [BUCKETS];
  node_t node_mem [POOL_NODES];
  logic [NW-1:0] free_mem [POOL_NODES];

  state_e state_q, state_d;
  logic [IW-1:0] sweep_q, sweep_d;
  logic [FW-1:0] top_q, top_d;
  logic [CW-1:0] count_q, count_d;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [1:0] func_q, func_d;
  head_t head_q, head_d;
  logic   prev_head_q, prev_head_d;   // predecessor of current node is head
  logic [NW-1:0] prev_q, prev_d, cur_q, cur_d;
  logic [SW-1:0] steps_q, steps_d;
  logic found_q, found_d, status_q, status_d;

  // Memory ports
  logic          h_we, n_we, f_we;
  logic [BW-1:0] h_wa, h_ra;
  logic [NW-1:0] n_wa, n_ra, f_wa, f_ra;
  head_t         h_wd, h_rd;
  node_t         n_wd, n_rd;
  logic [NW-1:0] f_wd, f_rd;

  always_ff @(posedge clk_i) begin
    if (h_we) head_mem[h_wa] <= h_wd;
    h_rd <= head_mem[h_ra];
  end
  always_ff @(posedge clk_i) begin
    if (n_we) node_mem[n_wa] <= n_wd;
    n_rd <= node_mem[n_ra];
  end
  always_ff @(posedge clk_i) begin
    if (f_we) free_mem[f_wa] <= f_wd;
    f_rd <= free_mem[f_ra];
  end

  // Bucket from hash under the clamped mask, modulo BUCKETS.
  logic [3:0]  bits_c;
  logic [16:0] mask_c;
  logic [BW-1:0] bkt_c;
  always_comb begin
    bits_c = (bits_i == 4'd0) ? 4'd1 : bits_i;
    mask_c = (17'd1 << bits_c) - 17'd1;
    bkt_c  = BW'((32'(mask_c) & hash_i) % BUCKETS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      sweep_q <= '0;
      top_q   <= FW'(POOL_NODES);
      count_q <= '0;
      func_q  <= FUNC_LOOKUP;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      top_q   <= top_d;
      count_q <= count_d;
      func_q  <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bkt_q <= bkt_d; key_q <= key_d; head_q <= head_d;
    prev_head_q <= prev_head_d; prev_q <= prev_d; cur_q <= cur_d;
    steps_q <= steps_d; found_q <= found_d; status_q <= status_d;
  end

  localparam int unsigned SweepMax = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;

  always_comb begin
    state_d = state_q; sweep_d = sweep_q; top_d = top_q; count_d = count_q;
    bkt_d = bkt_q; key_d = key_q; func_d = func_q; head_d = head_q;
    prev_head_d = prev_head_q; prev_d = prev_q; cur_d = cur_q;
    steps_d = steps_q; found_d = found_q; status_d = status_q;
    h_we = 1'b0; h_wa = bkt_q; h_wd = head_q; h_ra = bkt_q;
    n_we = 1'b0; n_wa = cur_q; n_wd = n_rd; n_ra = cur_q;
    f_we = 1'b0; f_wa = NW'(top_q); f_wd = cur_q; f_ra = NW'(top_q - FW'(1));
    done_o = 1'b0;
    case (state_q)
      S_INIT: begin
        // Clearing sweep: empty buckets and refill the free stack.
        if (32'(sweep_q) < BUCKETS) begin
          h_we = 1'b1; h_wa = BW'(sweep_q); h_wd = '0;
        end
        if (32'(sweep_q) < POOL_NODES) begin
          f_we = 1'b1; f_wa = NW'(sweep_q); f_wd = NW'(sweep_q);
        end
        if (32'(sweep_q) == SweepMax - 1) begin
          sweep_d = '0;
          top_d   = FW'(POOL_NODES);
          count_d = '0;
          state_d = (func_q == FUNC_CLEAR) ? S_DONE : S_IDLE;
        end else begin
          sweep_d = sweep_q + IW'(1);
        end
      end
      S_IDLE: begin
        func_d = FUNC_LOOKUP;
        if (start_i) begin
          func_d = func_i; bkt_d = bkt_c; key_d = KEY_BITS'(key_i);
          found_d = 1'b0; status_d = 1'b0;
          h_ra = bkt_c;
          state_d = (func_i == FUNC_CLEAR) ? S_INIT : S_HRD;
        end
      end
      S_HRD: begin
        head_d = h_rd;
        steps_d = '0; prev_head_d = 1'b1;
        cur_d = h_rd.next; n_ra = h_rd.next;
        f_ra = NW'(top_q - FW'(1));
        state_d = S_HEAD;
        if (!h_rd.valid) begin
          if (func_q == FUNC_INSERT) begin
            h_we = 1'b1; h_wd = '{valid: 1'b1, key: key_q, has_next: 1'b0, next: '0};
            count_d = count_q + CW'(1);
          end
          state_d = S_DONE;
        end else if (h_rd.key == key_q) begin
          found_d = 1'b1;
          if (func_q == FUNC_REMOVE) begin
            count_d = count_q - CW'(1);
            if (h_rd.has_next && 32'(h_rd.next) < POOL_NODES) begin
              state_d = S_RMH;
            end else begin
              h_we = 1'b1; h_wd = '0; h_wd.key = h_rd.key;
              state_d = S_DONE;
            end
          end else begin
            state_d = S_DONE;
          end
        end else if (!(h_rd.has_next && 32'(h_rd.next) < POOL_NODES)) begin
          state_d = (func_q == FUNC_INSERT) ? S_FREE : S_DONE;
        end else begin
          state_d = S_NODE;
        end
      end
      S_RMH: begin
        // Successor copied into the head; its node returns to the stack.
        h_we = 1'b1;
        h_wd = '{valid: 1'b1, key: n_rd.key, has_next: n_rd.has_next, next: n_rd.next};
        if (32'(top_q) < POOL_NODES) begin
          f_we = 1'b1; f_wa = NW'(top_q); f_wd = cur_q;
          top_d = top_q + FW'(1);
        end
        state_d = S_DONE;
      end
      S_NODE: begin
        // n_rd holds node cur_q.
        if (n_rd.key == key_q) begin
          found_d = 1'b1;
          if (func_q == FUNC_REMOVE) begin
            if (prev_head_q) begin
              h_we = 1'b1; h_wd = head_q;
              h_wd.has_next = n_rd.has_next; h_wd.next = n_rd.next;
            end else begin
              // prev node's key was captured in the key field of head_q
              n_we = 1'b1; n_wa = prev_q;
              n_wd = '{key: head_q.key, has_next: n_rd.has_next, next: n_rd.next};
            end
            if (32'(top_q) < POOL_NODES) begin
              f_we = 1'b1; f_wa = NW'(top_q); f_wd = cur_q;
              top_d = top_q + FW'(1);
            end
            count_d = count_q - CW'(1);
          end
          state_d = S_DONE;
        end else if (n_rd.has_next && 32'(n_rd.next) < POOL_NODES &&
                     32'(steps_q) < POOL_NODES - 1) begin
          steps_d = steps_q + SW'(1);
          if (func_q == FUNC_REMOVE) begin
            prev_head_d = 1'b0; prev_d = cur_q; head_d.key = n_rd.key;
          end
          cur_d = n_rd.next; n_ra = n_rd.next;
          state_d = S_NODE;
        end else begin
          state_d = (func_q == FUNC_INSERT) ? S_FREE : S_DONE;
        end
        f_ra = NW'(top_q - FW'(1));
      end
      S_FREE: begin
        // Key absent, head occupied: take a node from the stack.
        if (top_q == '0) begin
          status_d = 1'b1; state_d = S_DONE;
        end else begin
          f_ra = NW'(top_q - FW'(1));
          top_d = top_q - FW'(1);
          state_d = S_INS;
        end
      end
      S_INS: begin
        // Head written from head_q, which the walk altered for a remove only.
        h_ra = bkt_q;
        n_we = 1'b1; n_wa = f_rd;
        n_wd = '{key: key_q, has_next: head_q.has_next, next: head_q.next};
        h_we = 1'b1; h_wd = head_q; h_wd.has_next = 1'b1; h_wd.next = f_rd;
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        done_o = 1'b1;
        func_d = FUNC_LOOKUP;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = '{found: found_q & (func_q != FUNC_CLEAR),
                    status: status_q & (func_q != FUNC_CLEAR),
                    total: TotalBits'(count_q)};
endmodule

FILE: rtl/chained_hash_set.sv
// Top level of the chained hash set: channels, configuration register, engine.
//
// The chained hash set keeps a set of keys in a bucket table whose collisions
// chain through a pool of nodes taken from a free stack. Each beat on the
// s_axis channel is one operation (lookup, insert, remove or clear) with the
// key and its externally computed hash; the low bits of the hash, under the
// bucket_bits_in_use register, pick the bucket. Each operation returns one
// beat on m_axis with found, status and the element total after it.
// The cfg channel writes bucket_bits_in_use; the user must use it only while idle,
// and the block itself does not enforce this. An operation walks its chain node
// by node over the single read port of the node memory; an insert into an
// occupied bucket then takes a node from the free stack, and a remove of a head
// with a successor copies that successor into the head. One operation runs at
// a time. After reset, and on a clear, a sweep empties the buckets and refills
// the free stack while s_axis_tready stays low.
// A result waits in an output register while the receiver stalls; the next
// beat is taken once that register is free.
module chained_hash_set
  import chs_pkg::*;
#(
  parameter int unsigned KEY_BITS   = KeyBitsDef,
  parameter int unsigned BUCKETS    = BucketsDef,
  parameter int unsigned POOL_NODES = PoolNodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // func[1:0], key[33:2], key_hash[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // found[0], status[1], element_total[11:2]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CfgBits-1:0] cfg_data_i
);
  logic [CfgBits-1:0] bits_q;
  logic busy, done, out_full, start;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= CfgBits'(8);
    end else if (cfg_valid_i) begin
      bits_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  assign s_axis_tready = ~busy & ~out_full;
  assign start = s_axis_tvalid & s_axis_tready;

  chs_engine #(
    .KEY_BITS(KEY_BITS), .BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)
  ) u_engine (
    .clk_i, .rst_ni,
    .bits_i (bits_q),
    .start_i(start),
    .func_i (s_axis_tdata[1:0]),
    .key_i  (s_axis_tdata[33:2]),
    .hash_i (s_axis_tdata[65:34]),
    .busy_o (busy),
    .done_o (done),
    .res_o  (res)
  );

  chs_out_reg u_out (
    .clk_i, .rst_ni,
    .load_i(done), .res_i(res), .full_o(out_full),
    .m_axis_tready, .m_axis_tvalid, .m_axis_tdata
  );
endmodule

FILE: tb/chained_hash_set_tb.sv
// Testbench for the chained hash set: directed and random operations checked against a predictor.
module chained_hash_set_tb;
  import chs_pkg::*;

  localparam int unsigned NumBuckets = BucketsDef;
  localparam int unsigned NumNodes   = PoolNodesDef;
  localparam int unsigned CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // func[1:0], key[33:2], key_hash[65:34]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // found[0], status[1], element_total[11:2]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgBits-1:0] cfg_data_i;

  chained_hash_set i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a period of 12 time units.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The predictor keeps the set as a shadow of the bucket table and node pool.
  // Each bucket's chain is held as head slot plus linked nodes, exactly as the
  // block keeps it, so that free-stack order and head promotion match.
  logic        head_valid [NumBuckets];
  logic [31:0] head_key   [NumBuckets];
  logic        head_more  [NumBuckets];
  logic [7:0]  head_next  [NumBuckets];
  logic [31:0] node_key   [NumNodes];
  logic        node_more  [NumNodes];
  logic [7:0]  node_next  [NumNodes];
  logic [7:0]  free_stack [NumNodes];
  int unsigned free_depth;
  int unsigned key_count;
  logic [CfgBits-1:0] bucket_bits;

  result_t     pending_results [$];
  int unsigned error_count;
  int unsigned cycle_count;

  // Receiver behavior: percentage of cycles stalled, plus a long hold-off; sender gap percentage.
  int unsigned sink_stall_pct;
  int unsigned src_gap_pct;
  int unsigned hold_cycles;

  // Keys recently inserted, so random lookups and removes hit often.
  logic [31:0] recent_keys [$];
  logic [31:0] recent_hashes [$];

  function automatic void clear_shadow();
    for (int i = 0; i < NumBuckets; i++) begin
      head_valid[i] = 1'b0;
      head_key[i]   = '0;
      head_more[i]  = 1'b0;
      head_next[i]  = '0;
    end
    for (int i = 0; i < NumNodes; i++) free_stack[i] = i[7:0];
    free_depth = NumNodes;
    key_count  = 0;
  endfunction

  function automatic int unsigned bucket_index(logic [31:0] hash);
    int unsigned bits;
    bits = bucket_bits;
    if (bits < 1) bits = 1;
    if (bits > 16) bits = 16;
    return (hash & ((32'd1 << bits) - 1)) % NumBuckets;
  endfunction

  function automatic logic key_in_bucket(int unsigned b, logic [31:0] key);
    logic       more;
    logic [7:0] n;
    if (!head_valid[b]) return 1'b0;
    if (head_key[b] == key) return 1'b1;
    more = head_more[b];
    n    = head_next[b];
    for (int s = 0; s < NumNodes && more; s++) begin
      if (node_key[n] == key) return 1'b1;
      more = node_more[n];
      n    = node_next[n];
    end
    return 1'b0;
  endfunction

  function automatic void release_node(logic [7:0] n);
    if (free_depth < NumNodes) begin
      free_stack[free_depth] = n;
      free_depth++;
    end
  endfunction

  // Applies one operation to the shadow state and returns its result.
  function automatic result_t apply_operation(func_e op, logic [31:0] key, logic [31:0] hash);
    result_t    res;
    int unsigned b;
    logic [7:0] n;
    logic [7:0] prev;
    logic       prev_is_head;
    logic       more;
    res = '0;
    b   = bucket_index(hash);
    case (op)
      FUNC_LOOKUP: begin
        res.found = key_in_bucket(b, key);
      end
      FUNC_INSERT: begin
        if (key_in_bucket(b, key)) begin
          res.found = 1'b1;
        end else if (!head_valid[b]) begin
          head_valid[b] = 1'b1;
          head_key[b]   = key;
          head_more[b]  = 1'b0;
          head_next[b]  = '0;
          key_count++;
        end else if (free_depth == 0) begin
          res.status = 1'b1;
        end else begin
          free_depth--;
          n = free_stack[free_depth];
          node_key[n]  = key;
          node_more[n] = head_more[b];
          node_next[n] = head_next[b];
          head_more[b] = 1'b1;
          head_next[b] = n;
          key_count++;
        end
      end
      FUNC_REMOVE: begin
        if (head_valid[b]) begin
          if (head_key[b] == key) begin
            res.found = 1'b1;
            if (head_more[b]) begin
              n = head_next[b];
              head_key[b]  = node_key[n];
              head_more[b] = node_more[n];
              head_next[b] = node_next[n];
              release_node(n);
            end else begin
              head_valid[b] = 1'b0;
              head_more[b]  = 1'b0;
              head_next[b]  = '0;
            end
            key_count--;
          end else begin
            prev_is_head = 1'b1;
            prev = '0;
            more = head_more[b];
            n    = head_next[b];
            for (int s = 0; s < NumNodes && more; s++) begin
              if (node_key[n] == key) begin
                if (prev_is_head) begin
                  head_more[b] = node_more[n];
                  head_next[b] = node_next[n];
                end else begin
                  node_more[prev] = node_more[n];
                  node_next[prev] = node_next[n];
                end
                release_node(n);
                key_count--;
                res.found = 1'b1;
                break;
              end
              prev_is_head = 1'b0;
              prev = n;
              more = node_more[n];
              n    = node_next[n];
            end
          end
        end
      end
      default: begin
        clear_shadow();
      end
    endcase
    res.total = key_count[TotalBits-1:0];
    return res;
  endfunction

  // Sends one operation and files its expected result once it is accepted.
  // The valid line stays high after the beat until the sender idles or waits.
  task automatic send_operation(func_e op, logic [31:0] key, logic [31:0] hash);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_gap_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, hash, key, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_operation(op, key, hash));
    if (op == FUNC_INSERT) begin
      recent_keys.push_back(key);
      recent_hashes.push_back(hash);
      if (recent_keys.size() > 64) begin
        void'(recent_keys.pop_front());
        void'(recent_hashes.pop_front());
      end
    end
  endtask

  // Waits until every result is in, then idles for longer than a clear sweep takes.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NumBuckets + NumNodes + 8) @(posedge clk_i);
  endtask

  // Writes the bucket-bits register; only called with the block idle.
  task automatic write_bucket_bits(logic [CfgBits-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    bucket_bits = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: stalls at random or during a long hold-off, checks every beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          result_t want;
          result_t got;
          want = pending_results.pop_front();
          got  = '{found: m_axis_tdata[0], status: m_axis_tdata[1],
                   total: m_axis_tdata[11:2]};
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %b, actual %b", $time,
                     want.found, got.found);
            error_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %b, actual %b", $time,
                     want.status, got.status);
            error_count++;
          end
          if (got.total !== want.total) begin
            $display("%0t: element_total mismatch, expected %0d, actual %0d", $time,
                     want.total, got.total);
            error_count++;
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Extremes of the key and hash fields, every operation, present and absent keys.
  task automatic test_directed_ops();
    send_operation(FUNC_LOOKUP, 32'h0, 32'h0);
    send_operation(FUNC_REMOVE, 32'h0, 32'h0);
    send_operation(FUNC_INSERT, 32'h0, 32'h0);
    send_operation(FUNC_INSERT, 32'h0, 32'h0);
    send_operation(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(FUNC_INSERT, 32'h1234_5678, 32'hFFFF_FF00);
    send_operation(FUNC_INSERT, 32'hAAAA_5555, 32'h0000_0100);
    send_operation(FUNC_INSERT, 32'h5555_AAAA, 32'h8000_0000);
    send_operation(FUNC_LOOKUP, 32'h5555_AAAA, 32'h0);
    send_operation(FUNC_LOOKUP, 32'h1234_5678, 32'h0);
    send_operation(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(FUNC_REMOVE, 32'hAAAA_5555, 32'h0);
    send_operation(FUNC_REMOVE, 32'h0, 32'h0);
    send_operation(FUNC_REMOVE, 32'hDEAD_BEEF, 32'h0);
    send_operation(FUNC_LOOKUP, 32'h1234_5678, 32'h0);
    send_operation(FUNC_REMOVE, 32'h1234_5678, 32'h0);
    send_operation(FUNC_REMOVE, 32'h5555_AAAA, 32'h0);
    send_operation(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Fills one bucket past the pool so inserts are dropped, then removes every third
  // key with the receiver held off so the block backs up on its input, and clears.
  task automatic test_pool_exhaustion();
    for (int i = 0; i < NumNodes + 4; i++) send_operation(FUNC_INSERT, i, 32'h0000_0007);
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_operation(FUNC_LOOKUP, $urandom, 32'h7);
    for (int i = NumNodes + 3; i >= 0; i -= 3) send_operation(FUNC_REMOVE, i, 32'h7);
    send_operation(FUNC_CLEAR, 32'h0, 32'h0);
  endtask

  // Register extremes: one bucket bit, out-of-range values, changing mask with keys held.
  task automatic test_bucket_bits();
    write_bucket_bits(4'd0);
    for (int i = 0; i < 12; i++) send_operation(FUNC_INSERT, $urandom, $urandom);
    write_bucket_bits(4'd15);
    for (int i = 0; i < 12; i++) send_operation(FUNC_LOOKUP, recent_keys[i % recent_keys.size()],
                                                recent_hashes[i % recent_keys.size()]);
    write_bucket_bits(4'd1);
    send_operation(FUNC_CLEAR, 32'h0, 32'h0);
  endtask

  // Random operations: inserts of fresh keys, lookups and removes mostly of keys seen
  // recently, the rest fresh keys, with a rare clear.
  task automatic test_random_ops(int unsigned count);
    func_e       op;
    logic [31:0] key;
    logic [31:0] hash;
    int unsigned roll;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) op = FUNC_CLEAR;
      else if (roll < 45) op = FUNC_INSERT;
      else if (roll < 72) op = FUNC_LOOKUP;
      else op = FUNC_REMOVE;
      if (recent_keys.size() != 0 && $urandom_range(99) < 60 && op != FUNC_INSERT) begin
        pick = $urandom_range(recent_keys.size() - 1);
        key  = recent_keys[pick];
        hash = recent_hashes[pick];
      end else begin
        key  = $urandom;
        hash = $urandom;
        if ($urandom_range(1)) key = {24'd0, key[7:0]};
      end
      send_operation(op, key, hash);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    error_count   = 0;
    cycle_count   = 0;
    hold_cycles   = 0;
    bucket_bits   = 4'd8;
    src_gap_pct   = 25;
    sink_stall_pct = 50;
    clear_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_pool_exhaustion();
    test_bucket_bits();

    // Three rounds of random operations, each under a different bucket-bits setting.
    write_bucket_bits(4'd3);
    test_random_ops(330);
    src_gap_pct    = 50;
    sink_stall_pct = 25;
    write_bucket_bits(4'd8);
    test_random_ops(330);
    // Sender pauses until the block has answered everything.
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    write_bucket_bits(4'd5);
    test_random_ops(330);

    drain_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/chs_pkg.sv
rtl/chs_out_reg.sv
rtl/chs_engine.sv
rtl/chained_hash_set.sv
tb/chained_hash_set_tb.sv
